// ----- design/kalman_tracker_3d_const_velocity_defines.svh -----
// assertion macros for the kalman tracker checker
// used by kct_checker.sv, no other dependencies
`ifndef KALMAN_TRACKER_3D_CONST_VELOCITY_DEFINES_SVH
`define KALMAN_TRACKER_3D_CONST_VELOCITY_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define KCT_ASSERT_IMPL(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication, disabled while in reset
`define KCT_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ----- design/kct_pkg.sv -----
// shared types, op codes, scratch addresses and fixed point helpers
// for the kalman tracker; no dependencies
`default_nettype none

package kct_pkg;

	localparam int WW = 48;
	localparam int AW = 7;
	localparam int CW = 25;

	typedef logic [WW-1:0] word_t;
	typedef logic [AW-1:0] addr_t;
	typedef logic [3:0]    op_t;
	typedef logic [2:0]    kidx_t;

	localparam op_t OP_MOV    = 4'd0;
	localparam op_t OP_ADD    = 4'd1;
	localparam op_t OP_SUB    = 4'd2;
	localparam op_t OP_MUL    = 4'd3;
	localparam op_t OP_DIV    = 4'd4;
	localparam op_t OP_LDK    = 4'd5;
	localparam op_t OP_LDZ    = 4'd6;
	localparam op_t OP_LDACC  = 4'd7;
	localparam op_t OP_CLRACC = 4'd8;
	localparam op_t OP_ADDMUL = 4'd9;
	localparam op_t OP_SUBMUL = 4'd10;
	localparam op_t OP_STORE  = 4'd11;
	localparam op_t OP_OUT    = 4'd12;

	localparam kidx_t K_ZERO   = 3'd0;
	localparam kidx_t K_ONE    = 3'd1;
	localparam kidx_t K_PV     = 3'd2;
	localparam kidx_t K_MV     = 3'd3;
	localparam kidx_t K_CPOS   = 3'd4;
	localparam kidx_t K_CCROSS = 3'd5;
	localparam kidx_t K_CVEL   = 3'd6;

	localparam word_t W_ONE    = 48'd16777216;
	localparam word_t W_CPOS   = 48'd838861;
	localparam word_t W_CCROSS = 48'd2097152;
	localparam word_t W_CVEL   = 48'd5592405;
	localparam word_t W_MAX    = 48'h7FFF_FFFF_FFFF;
	localparam word_t W_MIN    = 48'h8000_0000_0000;

	localparam logic [CW-1:0] PV_RESET = 25'd16777;
	localparam logic [CW-1:0] MV_RESET = 25'd167772;

	// scratch layout
	localparam addr_t A_T  = 7'd117;
	localparam addr_t A_F  = 7'd118;
	localparam addr_t A_QP = 7'd119;
	localparam addr_t A_QC = 7'd120;
	localparam addr_t A_QV = 7'd121;

	typedef struct packed {
		logic  start;
		logic  load_meas;
		op_t   op;
		kidx_t k;
		addr_t ra;
		addr_t rb;
		addr_t wa;
	} dp_cmd_t;

	typedef struct packed {
		logic done;
	} dp_stat_t;

	function automatic addr_t ad_p(input logic [2:0] i, input logic [2:0] j);
		return addr_t'(6 * i + j);
	endfunction

	function automatic addr_t ad_a(input logic [2:0] i, input logic [2:0] j);
		return addr_t'(36 + 6 * i + j);
	endfunction

	function automatic addr_t ad_g(input logic [2:0] i, input logic [2:0] j);
		return addr_t'(72 + 6 * i + j);
	endfunction

	function automatic addr_t ad_k(input logic [2:0] i, input logic [2:0] j);
		return addr_t'(90 + 3 * i + j);
	endfunction

	function automatic addr_t ad_x(input logic [2:0] i);
		return addr_t'(108 + i);
	endfunction

	function automatic addr_t ad_y(input logic [2:0] i);
		return addr_t'(114 + i);
	endfunction

	function automatic addr_t ad_z(input logic [2:0] i);
		return addr_t'(122 + i);
	endfunction

	function automatic word_t magn(input word_t a);
		return a[WW-1] ? word_t'(-a) : a;
	endfunction

	// apply sign to an unsigned magnitude and saturate
	function automatic word_t sat_mag(input logic [51:0] m, input logic neg);
		word_t r;
		if (neg) begin
			if (m >= 52'h8000_0000_0000) r = W_MIN;
			else r = word_t'(-m);
		end else begin
			if (m > 52'h7FFF_FFFF_FFFF) r = W_MAX;
			else r = m[WW-1:0];
		end
		return r;
	endfunction

	function automatic word_t sat49(input logic [WW:0] s);
		word_t r;
		if (s[WW] != s[WW-1]) r = s[WW] ? W_MIN : W_MAX;
		else r = s[WW-1:0];
		return r;
	endfunction

	function automatic word_t sat_add(input word_t a, input word_t b);
		return sat49({a[WW-1], a} + {b[WW-1], b});
	endfunction

	function automatic word_t sat_sub(input word_t a, input word_t b);
		return sat49({a[WW-1], a} - {b[WW-1], b});
	endfunction

endpackage

`default_nettype wire

// ----- design/kalman_tracker_3d_const_velocity.sv -----
// Constant-velocity 3-D Kalman tracker, Q23.24 fixed point, saturating.
// Input channel in_valid/in_ready carries meas_x/y/z; output channel
// out_valid/out_ready carries filt_x/y/z, one result item per input item.
// The first item after reset loads the track and echoes the measurement.
// Every later item runs predict and update: the 18 divides of the 3x3
// Gauss-Jordan inverse run on the 72-step restoring divider, which skips
// its steps for a zero pivot; the 219 multiplies run in the shared
// multiplier with one 24x24 product per cycle; and the 307 simple ops go
// through the scratch memory.
// One item is in work at a time; in_ready is high while the block is idle,
// so a new item is taken only once work on the last one is done.
// A result held in the output registers does not block the next item; the
// new item runs until its result would overwrite the held one and then waits
// for out_ready. Config writes (cfg_we, cfg_index, cfg_data) go straight to
// the noise registers and belong between items.
// Reset clears control state, restores the default noise values and marks
// the track as not yet initialized; the scratch memory needs no clearing.
// depends on kct_pkg, kct_ctrl, kct_dp
`default_nettype none

module kalman_tracker_3d_const_velocity (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_we,
	input  wire logic           cfg_index,
	input  wire logic [24:0]    cfg_data,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire kct_pkg::word_t meas_x,
	input  wire kct_pkg::word_t meas_y,
	input  wire kct_pkg::word_t meas_z,
	output logic                out_valid,
	input  wire logic           out_ready,
	output kct_pkg::word_t      filt_x,
	output kct_pkg::word_t      filt_y,
	output kct_pkg::word_t      filt_z
);
	import kct_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	kct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	kct_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.meas_x    (meas_x),
		.meas_y    (meas_y),
		.meas_z    (meas_z),
		.filt_x    (filt_x),
		.filt_y    (filt_y),
		.filt_z    (filt_z)
	);

endmodule

`default_nettype wire

// ----- design/kct_mul.sv -----
// fixed point multiplier, four 24x24 partial products over cycles
// depends on kct_pkg
`default_nettype none

module kct_mul (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire kct_pkg::word_t a,
	input  wire kct_pkg::word_t b,
	output logic               done,
	output kct_pkg::word_t     p
);
	import kct_pkg::*;

	logic        busy_q;
	logic [2:0]  cnt_q;
	word_t       ua_q, ub_q;
	logic        neg_q;
	logic [47:0] prod_q;
	logic [50:0] sum_q;
	logic        ovf_q;
	logic [23:0] opa, opb;

	always_comb begin
		case (cnt_q)
			3'd0:    begin opa = ua_q[23:0];  opb = ub_q[23:0];  end
			3'd1:    begin opa = ua_q[47:24]; opb = ub_q[23:0];  end
			3'd2:    begin opa = ua_q[23:0];  opb = ub_q[47:24]; end
			default: begin opa = ua_q[47:24]; opb = ub_q[47:24]; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 3'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 3'd0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 3'd1;
			if (cnt_q == 3'd5) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ua_q  <= magn(a);
			ub_q  <= magn(b);
			neg_q <= a[WW-1] ^ b[WW-1];
		end else if (busy_q) begin
			if (cnt_q < 3'd4) prod_q <= opa * opb;
			case (cnt_q)
				3'd1: sum_q <= 51'((49'(prod_q) + 49'h80_0000) >> 24);
				3'd2, 3'd3: sum_q <= sum_q + 51'(prod_q);
				3'd4: begin
					// high product at or above 2^23 already overflows
					ovf_q <= (prod_q >= 48'h80_0000);
					sum_q <= sum_q + {prod_q[26:0], 24'd0};
				end
				default: ;
			endcase
		end
	end

	assign done = busy_q && (cnt_q == 3'd5);
	assign p    = ovf_q ? sat_mag(52'h8000_0000_0000, neg_q) : sat_mag({1'b0, sum_q}, neg_q);

endmodule

`default_nettype wire

// ----- design/kct_div.sv -----
// fixed point divider, restoring, one quotient bit per cycle (72 steps)
// depends on kct_pkg
`default_nettype none

module kct_div (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire kct_pkg::word_t a,
	input  wire kct_pkg::word_t b,
	output logic               done,
	output kct_pkg::word_t     q
);
	import kct_pkg::*;

	localparam int STEPS = 72;

	logic        busy_q;
	logic [6:0]  cnt_q;
	logic [71:0] num_q;
	word_t       ub_q;
	logic [47:0] r_q, q_q;
	logic        ovf_q, neg_q, zdiv_q, azero_q, aneg_q;
	logic [48:0] r_nx;
	logic        ge;
	logic        rnd;
	logic [48:0] qf;

	assign r_nx = {r_q, num_q[71]};
	assign ge   = r_nx >= {1'b0, ub_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 7'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= (b == '0) ? 7'd0 : 7'(STEPS);
		end else if (busy_q) begin
			if (cnt_q == 7'd0) busy_q <= 1'b0;
			else cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q   <= {magn(a), 24'd0};
			ub_q    <= magn(b);
			r_q     <= '0;
			q_q     <= '0;
			ovf_q   <= 1'b0;
			neg_q   <= a[WW-1] ^ b[WW-1];
			zdiv_q  <= (b == '0);
			azero_q <= (a == '0);
			aneg_q  <= a[WW-1];
		end else if (busy_q && cnt_q != 7'd0) begin
			num_q <= {num_q[70:0], 1'b0};
			r_q   <= ge ? 48'(r_nx - {1'b0, ub_q}) : r_nx[47:0];
			q_q   <= {q_q[46:0], ge};
			// quotient reaching 2^48 saturates
			if (q_q[47]) ovf_q <= 1'b1;
		end
	end

	assign rnd = {1'b0, r_q, 1'b0} >= {2'b00, ub_q};
	assign qf  = {1'b0, q_q} + 49'(rnd);

	always_comb begin
		if (zdiv_q) q = azero_q ? '0 : (aneg_q ? W_MIN : W_MAX);
		else if (ovf_q) q = sat_mag(52'h8000_0000_0000, neg_q);
		else q = sat_mag({3'b000, qf}, neg_q);
	end

	assign done = busy_q && (cnt_q == 7'd0);

endmodule

`default_nettype wire

// ----- design/kct_dp.sv -----
// datapath: scratch memory, accumulator, config registers, result registers
// depends on kct_pkg, kct_mul, kct_div
`default_nettype none

module kct_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire kct_pkg::dp_cmd_t  cmd,
	output kct_pkg::dp_stat_t      stat,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [24:0]       cfg_data,
	input  wire kct_pkg::word_t    meas_x,
	input  wire kct_pkg::word_t    meas_y,
	input  wire kct_pkg::word_t    meas_z,
	output kct_pkg::word_t         filt_x,
	output kct_pkg::word_t         filt_y,
	output kct_pkg::word_t         filt_z
);
	import kct_pkg::*;

	localparam logic [1:0] D_IDLE = 2'd0;
	localparam logic [1:0] D_EX   = 2'd1;
	localparam logic [1:0] D_MUL  = 2'd2;
	localparam logic [1:0] D_DIV  = 2'd3;

	localparam logic CFG_PV = 1'b0;
	localparam logic CFG_MV = 1'b1;

	logic [1:0]    dstate_q;
	dp_cmd_t       cmd_q;
	word_t         mem [0:(1 << AW) - 1];
	word_t         rda_q, rdb_q, acc_q;
	word_t         z_q [0:2];
	word_t         filt_q [0:2];
	logic [CW-1:0] pv_q, mv_q;

	logic  we, acc_ld, filt_ld, done;
	word_t wd, acc_nx;
	logic  mul_start, mul_done, div_start, div_done;
	word_t mul_p, div_q;
	word_t kval;

	always_comb begin
		case (cmd_q.k)
			K_ONE:    kval = W_ONE;
			K_PV:     kval = word_t'(pv_q);
			K_MV:     kval = word_t'(mv_q);
			K_CPOS:   kval = W_CPOS;
			K_CCROSS: kval = W_CCROSS;
			K_CVEL:   kval = W_CVEL;
			default:  kval = '0;
		endcase
	end

	kct_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (rda_q),
		.b      (rdb_q),
		.done   (mul_done),
		.p      (mul_p)
	);

	kct_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.a      (rda_q),
		.b      (rdb_q),
		.done   (div_done),
		.q      (div_q)
	);

	always_comb begin
		we        = 1'b0;
		wd        = rda_q;
		acc_ld    = 1'b0;
		acc_nx    = acc_q;
		filt_ld   = 1'b0;
		done      = 1'b0;
		mul_start = 1'b0;
		div_start = 1'b0;
		unique case (dstate_q)
			D_EX: begin
				case (cmd_q.op)
					OP_MOV:    begin we = 1'b1; wd = rda_q; done = 1'b1; end
					OP_ADD:    begin we = 1'b1; wd = sat_add(rda_q, rdb_q); done = 1'b1; end
					OP_SUB:    begin we = 1'b1; wd = sat_sub(rda_q, rdb_q); done = 1'b1; end
					OP_LDK:    begin we = 1'b1; wd = kval; done = 1'b1; end
					OP_LDZ:    begin we = 1'b1; wd = z_q[cmd_q.k[1:0]]; done = 1'b1; end
					OP_LDACC:  begin acc_ld = 1'b1; acc_nx = rda_q; done = 1'b1; end
					OP_CLRACC: begin acc_ld = 1'b1; acc_nx = '0; done = 1'b1; end
					OP_STORE:  begin we = 1'b1; wd = acc_q; done = 1'b1; end
					OP_OUT:    begin filt_ld = 1'b1; done = 1'b1; end
					OP_MUL, OP_ADDMUL, OP_SUBMUL: mul_start = 1'b1;
					OP_DIV:    div_start = 1'b1;
					default:   done = 1'b1;
				endcase
			end
			D_MUL: begin
				if (mul_done) begin
					done = 1'b1;
					case (cmd_q.op)
						OP_ADDMUL: begin acc_ld = 1'b1; acc_nx = sat_add(acc_q, mul_p); end
						OP_SUBMUL: begin acc_ld = 1'b1; acc_nx = sat_sub(acc_q, mul_p); end
						default:   begin we = 1'b1; wd = mul_p; end
					endcase
				end
			end
			D_DIV: begin
				if (div_done) begin
					done = 1'b1;
					we   = 1'b1;
					wd   = div_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dstate_q <= D_IDLE;
		end else begin
			unique case (dstate_q)
				D_IDLE: if (cmd.start) dstate_q <= D_EX;
				D_EX: begin
					if (mul_start) dstate_q <= D_MUL;
					else if (div_start) dstate_q <= D_DIV;
					else dstate_q <= D_IDLE;
				end
				D_MUL: if (mul_done) dstate_q <= D_IDLE;
				D_DIV: if (div_done) dstate_q <= D_IDLE;
				default: dstate_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q <= PV_RESET;
			mv_q <= MV_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PV: pv_q <= cfg_data;
				CFG_MV: mv_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[cmd_q.wa] <= wd;
		if (cmd.start) begin
			cmd_q <= cmd;
			rda_q <= mem[cmd.ra];
			rdb_q <= mem[cmd.rb];
		end
		if (acc_ld) acc_q <= acc_nx;
		if (filt_ld) filt_q[cmd_q.k[1:0]] <= rda_q;
		if (cmd.load_meas) begin
			z_q[0] <= meas_x;
			z_q[1] <= meas_y;
			z_q[2] <= meas_z;
		end
	end

	assign stat.done = done;
	assign filt_x    = filt_q[0];
	assign filt_y    = filt_q[1];
	assign filt_z    = filt_q[2];

endmodule

`default_nettype wire

// ----- design/kct_ctrl.sv -----
// controller: handshakes and the op sequence of one filter step
// depends on kct_pkg
`default_nettype none

module kct_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output kct_pkg::dp_cmd_t       cmd,
	input  wire kct_pkg::dp_stat_t stat
);
	import kct_pkg::*;

	localparam logic C_IDLE = 1'b0;
	localparam logic C_RUN  = 1'b1;

	localparam logic [4:0] PH_LZ   = 5'd0;
	localparam logic [4:0] PH_IX   = 5'd1;
	localparam logic [4:0] PH_IP   = 5'd2;
	localparam logic [4:0] PH_PX   = 5'd3;
	localparam logic [4:0] PH_ROW  = 5'd4;
	localparam logic [4:0] PH_COL  = 5'd5;
	localparam logic [4:0] PH_QK   = 5'd6;
	localparam logic [4:0] PH_QA   = 5'd7;
	localparam logic [4:0] PH_G    = 5'd8;
	localparam logic [4:0] PH_GR   = 5'd9;
	localparam logic [4:0] PH_PIV  = 5'd10;
	localparam logic [4:0] PH_DIV  = 5'd11;
	localparam logic [4:0] PH_FAC  = 5'd12;
	localparam logic [4:0] PH_ELIM = 5'd13;
	localparam logic [4:0] PH_K    = 5'd14;
	localparam logic [4:0] PH_Y    = 5'd15;
	localparam logic [4:0] PH_X    = 5'd16;
	localparam logic [4:0] PH_P    = 5'd17;
	localparam logic [4:0] PH_O    = 5'd18;

	logic       cstate_q, wait_q, init_q, out_valid_q;
	logic [4:0] phase_q;
	logic [2:0] i_q, j_q, s_q;
	logic [1:0] c_q, r_q;

	logic [2:0] i_lim, j_lim, s_lim, i_n, j_n, s_n, sm1, cc, rr;
	logic [2:0] rn;
	logic       last, accept, start, done;

	assign accept = in_valid && in_ready;
	assign done   = stat.done;
	assign sm1    = 3'(s_q - 3'd1);
	assign cc     = {1'b0, c_q};
	assign rr     = {1'b0, r_q};
	assign start  = (cstate_q == C_RUN) && !wait_q && !(phase_q == PH_O && out_valid_q);

	// loop bounds, s innermost then j then i
	always_comb begin
		i_lim = 3'd0;
		j_lim = 3'd0;
		s_lim = 3'd0;
		unique case (phase_q)
			PH_LZ, PH_PX, PH_Y: i_lim = 3'd2;
			PH_IX:   i_lim = 3'd5;
			PH_IP, PH_ROW: begin i_lim = 3'd5; j_lim = 3'd5; end
			PH_COL:  begin i_lim = 3'd5; j_lim = 3'd2; end
			PH_QK:   s_lim = 3'd6;
			PH_QA:   begin i_lim = 3'd2; s_lim = 3'd3; end
			PH_G:    begin i_lim = 3'd2; j_lim = 3'd5; end
			PH_GR:   begin i_lim = 3'd2; s_lim = 3'd1; end
			PH_DIV:  j_lim = 3'd5;
			PH_ELIM: begin j_lim = 3'd5; s_lim = 3'd2; end
			PH_K:    begin i_lim = 3'd5; j_lim = 3'd2; s_lim = 3'd4; end
			PH_X:    begin i_lim = 3'd5; s_lim = 3'd4; end
			PH_P:    begin i_lim = 3'd5; j_lim = 3'd5; s_lim = 3'd4; end
			PH_O:    s_lim = 3'd2;
			default: ;
		endcase
	end

	always_comb begin
		s_n  = s_q;
		j_n  = j_q;
		i_n  = i_q;
		last = 1'b0;
		if (s_q != s_lim) begin
			s_n = s_q + 3'd1;
		end else begin
			s_n = 3'd0;
			if (j_q != j_lim) begin
				j_n = j_q + 3'd1;
			end else begin
				j_n = 3'd0;
				if (i_q != i_lim) begin
					i_n = i_q + 3'd1;
				end else begin
					i_n  = 3'd0;
					last = 1'b1;
				end
			end
		end
	end

	// next elimination row, skipping the pivot row
	always_comb begin
		rn = rr + 3'd1;
		if (rn == cc) rn = rn + 3'd1;
	end

	always_comb begin
		cmd.start     = start;
		cmd.load_meas = accept;
		cmd.op        = OP_MOV;
		cmd.k         = K_ZERO;
		cmd.ra        = '0;
		cmd.rb        = '0;
		cmd.wa        = '0;
		unique case (phase_q)
			PH_LZ: begin cmd.op = OP_LDZ; cmd.k = i_q; cmd.wa = ad_z(i_q); end
			PH_IX: begin
				cmd.wa = ad_x(i_q);
				if (i_q < 3'd3) begin cmd.op = OP_MOV; cmd.ra = ad_z(i_q); end
				else begin cmd.op = OP_LDK; cmd.k = K_ZERO; end
			end
			PH_IP: begin
				cmd.op = OP_LDK;
				cmd.k  = (i_q == j_q) ? K_ONE : K_ZERO;
				cmd.wa = ad_p(i_q, j_q);
			end
			PH_PX: begin
				cmd.op = OP_ADD;
				cmd.ra = ad_x(i_q);
				cmd.rb = ad_x(i_q + 3'd3);
				cmd.wa = ad_x(i_q);
			end
			PH_ROW: begin
				cmd.ra = ad_p(i_q, j_q);
				cmd.wa = ad_a(i_q, j_q);
				if (i_q < 3'd3) begin cmd.op = OP_ADD; cmd.rb = ad_p(i_q + 3'd3, j_q); end
				else cmd.op = OP_MOV;
			end
			PH_COL: begin
				cmd.op = OP_ADD;
				cmd.ra = ad_a(i_q, j_q);
				cmd.rb = ad_a(i_q, j_q + 3'd3);
				cmd.wa = ad_a(i_q, j_q);
			end
			PH_QK: begin
				case (s_q)
					3'd0: begin cmd.op = OP_LDK; cmd.k = K_CPOS;   cmd.wa = A_QP; end
					3'd1: begin cmd.op = OP_LDK; cmd.k = K_CCROSS; cmd.wa = A_QC; end
					3'd2: begin cmd.op = OP_LDK; cmd.k = K_CVEL;   cmd.wa = A_QV; end
					3'd3: begin cmd.op = OP_LDK; cmd.k = K_PV;     cmd.wa = A_T;  end
					3'd4: begin cmd.op = OP_MUL; cmd.ra = A_QP; cmd.rb = A_T; cmd.wa = A_QP; end
					3'd5: begin cmd.op = OP_MUL; cmd.ra = A_QC; cmd.rb = A_T; cmd.wa = A_QC; end
					default: begin cmd.op = OP_MUL; cmd.ra = A_QV; cmd.rb = A_T; cmd.wa = A_QV; end
				endcase
			end
			PH_QA: begin
				cmd.op = OP_ADD;
				case (s_q)
					3'd0: begin cmd.ra = ad_a(i_q, i_q); cmd.rb = A_QP; end
					3'd1: begin cmd.ra = ad_a(i_q, i_q + 3'd3); cmd.rb = A_QC; end
					3'd2: begin cmd.ra = ad_a(i_q + 3'd3, i_q); cmd.rb = A_QC; end
					default: begin cmd.ra = ad_a(i_q + 3'd3, i_q + 3'd3); cmd.rb = A_QV; end
				endcase
				cmd.wa = cmd.ra;
			end
			PH_G: begin
				cmd.wa = ad_g(i_q, j_q);
				if (j_q < 3'd3) begin cmd.op = OP_MOV; cmd.ra = ad_a(i_q, j_q); end
				else begin
					cmd.op = OP_LDK;
					cmd.k  = (i_q == 3'(j_q - 3'd3)) ? K_ONE : K_ZERO;
				end
			end
			PH_GR: begin
				if (s_q == 3'd0) begin cmd.op = OP_LDK; cmd.k = K_MV; cmd.wa = A_T; end
				else begin
					cmd.op = OP_ADD;
					cmd.ra = ad_g(i_q, i_q);
					cmd.rb = A_T;
					cmd.wa = ad_g(i_q, i_q);
				end
			end
			PH_PIV: begin cmd.op = OP_MOV; cmd.ra = ad_g(cc, cc); cmd.wa = A_T; end
			PH_DIV: begin
				cmd.op = OP_DIV;
				cmd.ra = ad_g(cc, j_q);
				cmd.rb = A_T;
				cmd.wa = ad_g(cc, j_q);
			end
			PH_FAC: begin cmd.op = OP_MOV; cmd.ra = ad_g(rr, cc); cmd.wa = A_F; end
			PH_ELIM: begin
				case (s_q)
					3'd0: begin cmd.op = OP_LDACC; cmd.ra = ad_g(rr, j_q); end
					3'd1: begin cmd.op = OP_SUBMUL; cmd.ra = A_F; cmd.rb = ad_g(cc, j_q); end
					default: begin cmd.op = OP_STORE; cmd.wa = ad_g(rr, j_q); end
				endcase
			end
			PH_K: begin
				if (s_q == 3'd0) cmd.op = OP_CLRACC;
				else if (s_q == 3'd4) begin cmd.op = OP_STORE; cmd.wa = ad_k(i_q, j_q); end
				else begin
					cmd.op = OP_ADDMUL;
					cmd.ra = ad_a(i_q, sm1);
					cmd.rb = ad_g(sm1, j_q + 3'd3);
				end
			end
			PH_Y: begin
				cmd.op = OP_SUB;
				cmd.ra = ad_z(i_q);
				cmd.rb = ad_x(i_q);
				cmd.wa = ad_y(i_q);
			end
			PH_X: begin
				if (s_q == 3'd0) begin cmd.op = OP_LDACC; cmd.ra = ad_x(i_q); end
				else if (s_q == 3'd4) begin cmd.op = OP_STORE; cmd.wa = ad_x(i_q); end
				else begin cmd.op = OP_ADDMUL; cmd.ra = ad_k(i_q, sm1); cmd.rb = ad_y(sm1); end
			end
			PH_P: begin
				if (s_q == 3'd0) begin cmd.op = OP_LDACC; cmd.ra = ad_a(i_q, j_q); end
				else if (s_q == 3'd4) begin cmd.op = OP_STORE; cmd.wa = ad_p(i_q, j_q); end
				else begin cmd.op = OP_SUBMUL; cmd.ra = ad_k(i_q, sm1); cmd.rb = ad_a(sm1, j_q); end
			end
			PH_O: begin cmd.op = OP_OUT; cmd.k = s_q; cmd.ra = ad_x(s_q); end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cstate_q    <= C_IDLE;
			phase_q     <= PH_LZ;
			wait_q      <= 1'b0;
			init_q      <= 1'b0;
			out_valid_q <= 1'b0;
			i_q         <= 3'd0;
			j_q         <= 3'd0;
			s_q         <= 3'd0;
			c_q         <= 2'd0;
			r_q         <= 2'd0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (accept) begin
				cstate_q <= C_RUN;
				phase_q  <= PH_LZ;
				wait_q   <= 1'b0;
				i_q      <= 3'd0;
				j_q      <= 3'd0;
				s_q      <= 3'd0;
			end else if (start) begin
				wait_q <= 1'b1;
			end else if (wait_q && done) begin
				wait_q <= 1'b0;
				i_q    <= i_n;
				j_q    <= j_n;
				s_q    <= s_n;
				if (last) begin
					unique case (phase_q)
						PH_LZ:  phase_q <= init_q ? PH_PX : PH_IX;
						PH_IX:  phase_q <= PH_IP;
						PH_IP: begin
							phase_q <= PH_O;
							init_q  <= 1'b1;
						end
						PH_PX:  phase_q <= PH_ROW;
						PH_ROW: phase_q <= PH_COL;
						PH_COL: phase_q <= PH_QK;
						PH_QK:  phase_q <= PH_QA;
						PH_QA:  phase_q <= PH_G;
						PH_G:   phase_q <= PH_GR;
						PH_GR: begin
							phase_q <= PH_PIV;
							c_q     <= 2'd0;
						end
						PH_PIV: phase_q <= PH_DIV;
						PH_DIV: begin
							phase_q <= PH_FAC;
							r_q     <= (c_q == 2'd0) ? 2'd1 : 2'd0;
						end
						PH_FAC: phase_q <= PH_ELIM;
						PH_ELIM: begin
							if (rn < 3'd3) begin
								r_q     <= rn[1:0];
								phase_q <= PH_FAC;
							end else if (c_q == 2'd2) begin
								phase_q <= PH_K;
							end else begin
								c_q     <= c_q + 2'd1;
								phase_q <= PH_PIV;
							end
						end
						PH_K:   phase_q <= PH_Y;
						PH_Y:   phase_q <= PH_X;
						PH_X:   phase_q <= PH_P;
						PH_P:   phase_q <= PH_O;
						PH_O: begin
							cstate_q    <= C_IDLE;
							out_valid_q <= 1'b1;
						end
						default: phase_q <= PH_LZ;
					endcase
				end
			end
		end
	end

	assign in_ready  = (cstate_q == C_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ----- design/kct_checker.sv -----
// port-level checker for the kalman tracker, bound to the top level
// depends on kct_pkg and kalman_tracker_3d_const_velocity_defines.svh
`default_nettype none
`include "kalman_tracker_3d_const_velocity_defines.svh"

module kct_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           cfg_we,
	input wire logic           cfg_index,
	input wire logic [24:0]    cfg_data,
	input wire logic           in_valid,
	input wire logic           in_ready,
	input wire kct_pkg::word_t meas_x,
	input wire kct_pkg::word_t meas_y,
	input wire kct_pkg::word_t meas_z,
	input wire logic           out_valid,
	input wire logic           out_ready,
	input wire kct_pkg::word_t filt_x,
	input wire kct_pkg::word_t filt_y,
	input wire kct_pkg::word_t filt_z
);
	import kct_pkg::*;

	// one item in work at a time
	`KCT_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready, "in_ready high right after an accepted item")

	// a taken result is not shown again in the next cycle
	`KCT_ASSERT_NEXT(a_no_repeat, clk, arst_n, out_valid && out_ready, !out_valid, "result item repeated")

	// a result only appears at the end of work on an item
	`KCT_ASSERT_IMPL(a_result_from_work, clk, arst_n, $rose(out_valid), !$past(in_ready), "result item without an item in work")

	// a stalled result holds its value
	`KCT_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(filt_x) && $stable(filt_y) && $stable(filt_z), "stalled result changed")

endmodule

bind kalman_tracker_3d_const_velocity kct_checker u_kct_checker (.*);

`default_nettype wire
